// ----- rtl/core/utf8_stream_decoder_core_assert.svh -----
// Assertion macros for the UTF-8 stream decoder core.
// Taken in by the top level; no other dependencies.
`ifndef UTF8_STREAM_DECODER_CORE_ASSERT_SVH
`define UTF8_STREAM_DECODER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define UTF8SD_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("utf8sd: forbidden condition seen");
`define UTF8SD_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("utf8sd: implication failed");
`define UTF8SD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("utf8sd: next-cycle implication failed");
`else
`define UTF8SD_ASSERT_NEVER(label, clk, rst, expr)
`define UTF8SD_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define UTF8SD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/core/utf8sd_pkg.sv -----
// Shared types and constants of the UTF-8 stream decoder core.
// No dependencies; used by every module of the core.
`default_nettype none

package utf8sd_pkg;

   localparam int OFFSET_BITS = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [31:0] BOM_CODE_POINT = 32'h0000_FEFF;
   localparam int          BOM_POSITION   = 3;
   localparam logic [1:0]  CONT_TAG       = 2'b10;

   typedef struct packed {
      logic [31:0] code_point;
      logic        whole;
      logic        valid_res;
      logic [31:0] good_offset;
   } res_type;

   typedef struct packed {
      logic    two;
      res_type r0;
      res_type r1;
   } entry_type;

endpackage

`default_nettype wire

// ----- rtl/core/utf8sd_front.sv -----
// Front end: accepts bytes, tracks the decoding state and builds one queue entry
// holding the one or two results that a byte causes. Depends on utf8sd_pkg.
`default_nettype none

module utf8sd_front import utf8sd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_string_end,
   input  wire logic        queue_full,
   output logic             push_valid,
   output entry_type        push_entry
);

   logic [31:0]            acc_ff, acc_in, acc;
   logic [2:0]             rem_ff, rem_in, rem;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in, pos;
   logic [OFFSET_BITS-1:0] lgp_ff, lgp_in, lgp;
   logic                   first_ff, first_in, first;
   logic                   done;
   logic [1:0]             nres;
   res_type                res, r0, r1;
   logic                   accept;
   logic [7:0]             b;

   function automatic logic [31:0] clamp_offset(input logic [OFFSET_BITS-1:0] p);
      logic [63:0] w;
      begin
         w = 64'(p);
         clamp_offset = (w > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
      end
   endfunction

   function automatic logic [2:0] lead_remaining(input logic [7:0] lead);
      logic [2:0] r;
      begin
         r = 3'd0;
         priority casez (lead)
            8'b110?????: r = 3'd1;
            8'b1110????: r = 3'd2;
            8'b11110???: r = 3'd3;
            8'b111110??: r = 3'd4;
            8'b1111110?: r = 3'd5;
            8'b1111111?: r = 3'd6;
            default:     r = 3'd0;
         endcase
         lead_remaining = r;
      end
   endfunction

   assign accept    = req_valid && !queue_full;
   assign req_stall = queue_full;
   assign b         = req_data_byte;

   always_comb begin
      acc   = acc_ff;
      rem   = rem_ff;
      lgp   = lgp_ff;
      first = first_ff;
      pos   = pos_ff;
      done  = 1'b0;
      nres  = 2'd0;
      res   = '0;
      r0    = '0;
      r1    = '0;
      if (pos_ff != {OFFSET_BITS{1'b1}}) begin
         pos = pos_ff + 1'b1;
      end

      if (rem_ff != 3'd0) begin
         if (b == 8'h00) begin
            res   = '{code_point: acc, whole: 1'b0, valid_res: 1'b1,
                      good_offset: clamp_offset(lgp)};
            r0    = res;
            nres  = 2'd1;
            first = 1'b0;
            rem   = 3'd0;
         end else if (b[7:6] == CONT_TAG) begin
            acc  = {acc[25:0], b[5:0]};
            rem  = rem - 3'd1;
            done = 1'b1;
            if (rem == 3'd0) begin
               if (first && acc == BOM_CODE_POINT &&
                   pos == OFFSET_BITS'(BOM_POSITION)) begin
                  first = 1'b0;
               end else begin
                  lgp   = pos;
                  res   = '{code_point: acc, whole: 1'b1, valid_res: 1'b1,
                            good_offset: clamp_offset(lgp)};
                  r0    = res;
                  nres  = 2'd1;
                  first = 1'b0;
               end
            end
         end else begin
            lgp   = pos_ff;
            res   = '{code_point: acc, whole: 1'b1, valid_res: 1'b0,
                      good_offset: clamp_offset(lgp)};
            r0    = res;
            nres  = 2'd1;
            first = 1'b0;
            rem   = 3'd0;
         end
      end

      if (!done) begin
         if (!b[7]) begin
            acc = 32'(b);
            lgp = pos;
            res = '{code_point: acc, whole: 1'b1, valid_res: 1'b1,
                    good_offset: clamp_offset(lgp)};
            if (nres == 2'd0) begin
               r0 = res;
            end else begin
               r1 = res;
            end
            nres  = nres + 2'd1;
            first = 1'b0;
         end else if (b[7:6] == CONT_TAG) begin
            acc = 32'(b);
            lgp = pos_ff;
            res = '{code_point: acc, whole: 1'b1, valid_res: 1'b0,
                    good_offset: clamp_offset(lgp)};
            if (nres == 2'd0) begin
               r0 = res;
            end else begin
               r1 = res;
            end
            nres  = nres + 2'd1;
            first = 1'b0;
         end else begin
            rem = lead_remaining(b);
            acc = 32'(b & (8'h7F >> 3'(rem + 3'd1)));
         end
      end

      if (req_string_end && rem != 3'd0) begin
         res = '{code_point: acc, whole: 1'b0, valid_res: 1'b1,
                 good_offset: clamp_offset(lgp)};
         if (nres == 2'd0) begin
            r0 = res;
         end else begin
            r1 = res;
         end
         nres  = nres + 2'd1;
         first = 1'b0;
      end
   end

   always_comb begin
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      pos_in   = pos_ff;
      lgp_in   = lgp_ff;
      first_in = first_ff;
      if (accept) begin
         if (req_string_end) begin
            acc_in   = '0;
            rem_in   = '0;
            pos_in   = '0;
            lgp_in   = '0;
            first_in = 1'b1;
         end else begin
            acc_in   = acc;
            rem_in   = rem;
            pos_in   = pos;
            lgp_in   = lgp;
            first_in = first;
         end
      end
   end

   assign push_valid = accept && (nres != 2'd0);
   assign push_entry = '{two: nres[1], r0: r0, r1: r1};

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         rem_ff   <= '0;
         pos_ff   <= '0;
         lgp_ff   <= '0;
         first_ff <= 1'b1;
      end else begin
         acc_ff   <= acc_in;
         rem_ff   <= rem_in;
         pos_ff   <= pos_in;
         lgp_ff   <= lgp_in;
         first_ff <= first_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/utf8sd_queue.sv -----
// Short queue of result entries between the front end and the output stage.
// Depends on utf8sd_pkg.
`default_nettype none

module utf8sd_queue import utf8sd_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push_valid,
   input  entry_type       push_entry,
   input  wire logic       pop,
   output logic            full,
   output logic            head_valid,
   output entry_type       head_entry
);

   entry_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/utf8sd_back.sv -----
// Back end: takes queue entries apart into single results and holds each one
// in the output register until the receiver takes it. Depends on utf8sd_pkg.
`default_nettype none

module utf8sd_back import utf8sd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        head_valid,
   input  entry_type        head_entry,
   output logic             pop,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_code_point,
   output logic             rsp_whole,
   output logic             rsp_valid_res,
   output logic [31:0]      rsp_good_offset,
   output logic             rsp_run_last
);

   logic    valid_ff, valid_in;
   logic    sel_ff, sel_in;
   res_type res_ff, res_in, cur;
   logic    last_ff, last_in, last;
   logic    load;

   assign load = !valid_ff || !rsp_stall;
   assign cur  = sel_ff ? head_entry.r1 : head_entry.r0;
   assign last = !head_entry.two || sel_ff;

   always_comb begin
      valid_in = valid_ff;
      sel_in   = sel_ff;
      res_in   = res_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = head_valid;
         if (head_valid) begin
            res_in  = cur;
            last_in = last;
            if (last) begin
               pop    = 1'b1;
               sel_in = 1'b0;
            end else begin
               sel_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff  <= res_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_code_point  = res_ff.code_point;
   assign rsp_whole       = res_ff.whole;
   assign rsp_valid_res   = res_ff.valid_res;
   assign rsp_good_offset = res_ff.good_offset;
   assign rsp_run_last    = last_ff;

endmodule

`default_nettype wire

// ----- rtl/core/utf8_stream_decoder_core.sv -----
// Top level of the lax UTF-8 stream decoder core.
// Depends on utf8sd_pkg, utf8sd_front, utf8sd_queue, utf8sd_back and the
// assertion macro header.
//
// Usage: the req channel carries one string byte per transaction, with
// req_string_end set on the final byte of a string. The rsp channel carries
// one decoded code point per transaction with its flags and byte offset;
// rsp_run_last marks the last result caused by a given input byte. A byte
// causes zero, one or two results. A transaction moves at a rising edge where
// valid is high and stall is low.
// A result is written into the queue at the edge that accepts its byte, moves into
// the output register once that register is free, and waits there for the receiver.
// Input runs at one byte per cycle while each byte gives at most one result and the
// receiver does not stall. A byte with two results keeps its queue entry until both
// have gone out; the four-entry queue absorbs these, and a long run of them slows the input.
// When the receiver stalls, the output register holds its result, the queue
// fills, and req_stall rises once the queue is full.
// Reset clears the decoding state, empties the queue and drops rsp_valid; the
// block can accept a byte as soon as reset is released.
`default_nettype none

`include "utf8_stream_decoder_core_assert.svh"

module utf8_stream_decoder_core import utf8sd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_string_end,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_code_point,
   output logic             rsp_whole,
   output logic             rsp_valid_res,
   output logic [31:0]      rsp_good_offset,
   output logic             rsp_run_last
);

   logic      q_full;
   logic      push_valid;
   entry_type push_entry;
   logic      pop;
   logic      head_valid;
   entry_type head_entry;

   utf8sd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_string_end (req_string_end),
      .queue_full     (q_full),
      .push_valid     (push_valid),
      .push_entry     (push_entry)
   );

   utf8sd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   utf8sd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_entry      (head_entry),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_point  (rsp_code_point),
      .rsp_whole       (rsp_whole),
      .rsp_valid_res   (rsp_valid_res),
      .rsp_good_offset (rsp_good_offset),
      .rsp_run_last    (rsp_run_last)
   );

   `UTF8SD_ASSERT_NEVER(a_no_push_when_full, clock, reset, push_valid && q_full)
   `UTF8SD_ASSERT_IMPLIES(a_pop_needs_head, clock, reset, pop, head_valid)
   `UTF8SD_ASSERT_NEXT(a_pair_back_to_back, clock, reset,
      rsp_valid && !rsp_stall && !rsp_run_last, rsp_valid)

endmodule

`default_nettype wire

// ----- tb/utf8_stream_decoder_core_test.sv -----
// Self-checking testbench for utf8_stream_decoder_core: random and directed byte strings,
// predicted code points compared per field against the rsp channel.
// Depends on utf8sd_pkg and the core's top level only.
`timescale 1ns / 100ps

module utf8_stream_decoder_core_test;
   import utf8sd_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int LONG_HOLD      = 60;
   localparam int TAIL_CYCLES    = 10;

   typedef struct packed {
      logic [7:0] data;
      logic       fin;
   } byte_item_type;

   typedef struct packed {
      logic [31:0] code_point;
      logic        whole;
      logic        valid_res;
      logic [31:0] good_offset;
      logic        run_last;
   } cp_result_type;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte  = 8'h00;
   logic        req_string_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [31:0] rsp_code_point;
   logic        rsp_whole;
   logic        rsp_valid_res;
   logic [31:0] rsp_good_offset;
   logic        rsp_run_last;

   byte_item_type  pending_bytes[$];
   cp_result_type  expected_cps[$];
   byte_item_type  next_byte;
   cp_result_type  want;
   logic        req_took    = 1'b0;
   bit          idle_on     = 1'b1;
   int          send_gap    = 0;
   int          stall_gap   = 0;
   int          hold_left   = 0;
   int          hold_asks   = 0;
   int          hold_taken  = 0;
   int          idle_cycles = 0;
   int          error_count = 0;

   // Decoder state mirrored by the predictor.
   logic [31:0] cp_acc          = '0;
   int          cont_left       = 0;
   logic [31:0] byte_pos        = '0;
   logic [31:0] good_pos        = '0;
   bit          at_string_start = 1'b1;

   utf8_stream_decoder_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_string_end  (req_string_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_point  (rsp_code_point),
      .rsp_whole       (rsp_whole),
      .rsp_valid_res   (rsp_valid_res),
      .rsp_good_offset (rsp_good_offset),
      .rsp_run_last    (rsp_run_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic cp_result_type make_cp(logic [31:0] cp, logic whole, logic vres);
      cp_result_type r;
      r.code_point  = cp;
      r.whole       = whole;
      r.valid_res   = vres;
      r.good_offset = good_pos;
      r.run_last    = 1'b0;
      at_string_start = 1'b0;
      return r;
   endfunction

   task automatic decode_byte(input logic [7:0] b, input logic fin);
      cp_result_type outs[$];
      logic [31:0] prev_pos;
      bit          consumed;
      int          ones;
      int          len;
      prev_pos = byte_pos;
      consumed = 1'b0;
      if (byte_pos != '1) byte_pos++;
      if (cont_left > 0) begin
         if (b == 8'h00) begin
            outs.push_back(make_cp(cp_acc, 1'b0, 1'b1));
            cont_left = 0;
         end else if (b[7:6] == CONT_TAG) begin
            cp_acc = {cp_acc[25:0], b[5:0]};
            cont_left--;
            if (cont_left == 0) begin
               if (at_string_start && cp_acc == BOM_CODE_POINT && byte_pos == BOM_POSITION) begin
                  at_string_start = 1'b0;
               end else begin
                  good_pos = byte_pos;
                  outs.push_back(make_cp(cp_acc, 1'b1, 1'b1));
               end
            end
            consumed = 1'b1;
         end else begin
            good_pos = prev_pos;
            outs.push_back(make_cp(cp_acc, 1'b1, 1'b0));
            cont_left = 0;
         end
      end
      if (!consumed) begin
         if (b < 8'h80) begin
            cp_acc   = {24'h0, b};
            good_pos = byte_pos;
            outs.push_back(make_cp(cp_acc, 1'b1, 1'b1));
         end else if (b[7:6] == CONT_TAG) begin
            cp_acc   = {24'h0, b};
            good_pos = prev_pos;
            outs.push_back(make_cp(cp_acc, 1'b1, 1'b0));
         end else begin
            ones = 0;
            while (ones < 8 && b[7 - ones]) ones++;
            len = (ones > 7) ? 7 : ones;
            cont_left = len - 1;
            cp_acc = {24'h0, b} & ((32'h1 << (7 - len)) - 32'h1);
         end
      end
      if (fin && cont_left > 0) outs.push_back(make_cp(cp_acc, 1'b0, 1'b1));
      if (outs.size() > 0) outs[outs.size() - 1].run_last = 1'b1;
      foreach (outs[i]) expected_cps.push_back(outs[i]);
      if (fin) begin
         cp_acc          = '0;
         cont_left       = 0;
         byte_pos        = '0;
         good_pos        = '0;
         at_string_start = 1'b1;
      end
   endtask

   function automatic logic [7:0] lead_byte(int len);
      logic [7:0] mask;
      logic [7:0] b;
      mask = 8'((1 << (7 - len)) - 1);
      b = (8'hFF << (8 - len)) | (8'($urandom) & mask);
      if (len == 7) b = b | 8'($urandom_range(0, 1));
      return b;
   endfunction

   function automatic logic [7:0] cont_byte();
      return {CONT_TAG, 6'($urandom)};
   endfunction

   task automatic send(input logic [7:0] b, input logic fin);
      byte_item_type it;
      it.data = b;
      it.fin  = fin;
      pending_bytes.push_back(it);
   endtask

   task automatic queue_random_string(output int n_bytes);
      logic [7:0] seq[$];
      int         n_cps;
      int         kind;
      int         len;
      int         k;
      n_cps = $urandom_range(1, 10);
      if ($urandom_range(0, 7) == 0) begin
         seq.push_back(8'hEF);
         seq.push_back(8'hBB);
         seq.push_back(8'hBF);
      end
      for (int i = 0; i < n_cps; i++) begin
         kind = $urandom_range(0, 15);
         len  = (kind >= 9 && kind <= 10) ? $urandom_range(5, 7) : $urandom_range(2, 4);
         if (kind <= 4 || kind == 15) begin
            seq.push_back(($urandom_range(0, 10) == 0) ? 8'h00 : 8'($urandom_range(1, 127)));
         end else if (kind <= 10) begin
            seq.push_back(lead_byte(len));
            for (int j = 1; j < len; j++) seq.push_back(cont_byte());
         end else if (kind == 11) begin
            seq.push_back(8'($urandom_range(0, 255)));
         end else if (kind == 12 || kind == 13) begin
            len = $urandom_range(2, 7);
            k   = $urandom_range(0, len - 2);
            seq.push_back(lead_byte(len));
            for (int j = 0; j < k; j++) seq.push_back(cont_byte());
            if (kind == 13) seq.push_back(8'h00);
            else if ($urandom_range(0, 1) == 0) seq.push_back(8'($urandom_range(1, 127)));
            else seq.push_back(lead_byte($urandom_range(2, 7)));
         end else begin
            k = $urandom_range(1, 2);
            for (int j = 0; j < k; j++) seq.push_back(cont_byte());
         end
      end
      if ($urandom_range(0, 5) == 0) begin
         len = $urandom_range(2, 7);
         k   = $urandom_range(0, len - 2);
         seq.push_back(lead_byte(len));
         for (int j = 0; j < k; j++) seq.push_back(cont_byte());
      end
      foreach (seq[i]) send(seq[i], i == seq.size() - 1);
      n_bytes = seq.size();
   endtask

   task automatic queue_random_bytes(input int target);
      int count;
      int n;
      count = 0;
      while (count < target) begin
         queue_random_string(n);
         count += n;
      end
   endtask

   task automatic wait_drained();
      while (pending_bytes.size() > 0 || req_valid || expected_cps.size() > 0)
         @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(0, 2);
            req_valid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            next_byte = pending_bytes.pop_front();
            req_valid      <= 1'b1;
            req_data_byte  <= next_byte.data;
            req_string_end <= next_byte.fin;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_asks != hold_taken) begin
         hold_taken = hold_asks;
         hold_left  = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else if (stall_gap > 0) begin
         stall_gap--;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_gap = $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         req_took <= req_valid && !req_stall;
         if (req_valid && !req_stall) decode_byte(req_data_byte, req_string_end);
         if (rsp_valid && !rsp_stall) begin
            if (expected_cps.size() == 0) begin
               $error("unexpected result: code_point %h", rsp_code_point);
               error_count++;
            end else begin
               want = expected_cps.pop_front();
               if (rsp_code_point !== want.code_point) begin
                  $error("code_point: expected %h, got %h", want.code_point, rsp_code_point);
                  error_count++;
               end
               if (rsp_whole !== want.whole) begin
                  $error("whole: expected %b, got %b", want.whole, rsp_whole);
                  error_count++;
               end
               if (rsp_valid_res !== want.valid_res) begin
                  $error("valid_res: expected %b, got %b", want.valid_res, rsp_valid_res);
                  error_count++;
               end
               if (rsp_good_offset !== want.good_offset) begin
                  $error("good_offset: expected %0d, got %0d", want.good_offset,
                         rsp_good_offset);
                  error_count++;
               end
               if (rsp_run_last !== want.run_last) begin
                  $error("run_last: expected %b, got %b", want.run_last, rsp_run_last);
                  error_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Byte-order mark, then the largest ASCII value.
      send(8'hEF, 1'b0); send(8'hBB, 1'b0); send(8'hBF, 1'b0); send(8'h7F, 1'b1);
      // Zero byte, stray continuation, broken sequence, zero inside a sequence.
      send(8'h00, 1'b0); send(8'h80, 1'b0); send(8'hC3, 1'b0); send(8'h41, 1'b0);
      send(8'hE2, 1'b0); send(8'h00, 1'b1);
      // Longest lax lead with six continuations overflows the accumulator.
      send(8'hFF, 1'b0);
      for (int i = 0; i < 6; i++) send(8'hBF, i == 5);
      // Four-byte sequence, then a lead cut off by the end of the string.
      send(8'hF0, 1'b0); send(8'h9F, 1'b0); send(8'h98, 1'b0); send(8'h80, 1'b0);
      send(8'hC3, 1'b1);
      // Sequence broken by a new lead byte.
      send(8'hE2, 1'b0); send(8'hC3, 1'b0); send(8'hA9, 1'b1);
      wait_drained();

      queue_random_bytes(200);
      hold_asks++;
      wait_drained();

      queue_random_bytes(300);
      wait_drained();

      idle_on = 1'b0;
      queue_random_bytes(150);
      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);

      if (error_count == 0 && expected_cps.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
